// ===== rtl/ircq_pkg.sv =====
`default_nettype none

package ircq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned FLAGS_W = 6;
	localparam int unsigned CRED_W  = 6;

	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 48;

	localparam logic FUNC_ENQUEUE = 1'b0;
	localparam logic FUNC_IRQ     = 1'b1;

	localparam logic [ADDR_W-1:0]  ADDR_OFFSET = 32'h8000_0000;
	localparam logic [FLAGS_W-1:0] IRQ_MASK    = 6'h30;
	localparam logic [FLAGS_W-1:0] CTRL_X1     = 6'h01;
	localparam logic [FLAGS_W-1:0] CTRL_Y2     = 6'h02;
	localparam logic [FLAGS_W-1:0] CTRL_X2     = 6'h08;

	localparam logic signed [CRED_W-1:0] CREDIT_MAX   = 6'sd31;
	localparam logic signed [CRED_W-1:0] CREDIT_RESET = 6'sd1;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_FULL = 2'd1,
		STATUS_NULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [FLAGS_W-1:0] kick_ctrl_value;
		logic [ADDR_W-1:0]  send_address;
		logic               send_valid;
		logic [FLAGS_W-1:0] ack_ctrl_value;
		logic               ack_issued;
		status_t            status;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/ipc_request_credit_queue.sv =====
// Channel  Dir  Signals                         Contents
// s_*      in   s_tvalid s_tready s_tdata s_tuser  one request or interrupt event
// m_*      out  m_tvalid m_tready m_tdata          one result per input transfer
//
// One transfer per cycle sustained while results are taken; each input is registered in
// the input stage and its result in the output register. The ring head is read from the
// ring RAM into a register ahead of use; a write to the slot being read is forwarded around the RAM.
// Reset clears the slots, count and output valid and sets credits to 1; the ring
// RAM is not cleared. A stalled result holds the input stage, which then holds s_tready.
`default_nettype none

module ipc_request_credit_queue
	import ircq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// request_address[31:0], extra_credit[32], ctrl_flags[38:33], zero[39]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// func[0]
	input  wire logic                 s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// status[1:0], ack_issued[2], ack_ctrl_value[8:3], send_valid[9],
	// send_address[41:10], kick_ctrl_value[47:42]
	output logic [M_TDATA_W-1:0]      m_tdata
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned ENT_W = ADDR_W + 1;

	logic               valid_s1;
	logic               func_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               extra_s1;
	logic [FLAGS_W-1:0] flags_s1;

	logic [PTR_W-1:0]         wr_slot_q;
	logic [PTR_W-1:0]         rd_slot_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [CRED_W-1:0] credits_q;

	logic [ENT_W-1:0] ring_q [QUEUE_DEPTH];
	logic [ENT_W-1:0] rdata_q;
	logic             byp_q;
	logic [ENT_W-1:0] byp_data_q;

	logic                 out_valid_q;
	result_t              out_q;

	logic                     advance;
	logic                     enq_ok;
	logic                     ack;
	logic                     may_send;
	logic                     send_ok;
	logic signed [CRED_W-1:0] cred_up;
	logic signed [CRED_W-1:0] cred_d;
	logic [ENT_W-1:0]         head;
	logic [ENT_W-1:0]         entry;
	logic [ENT_W-1:0]         wdata;
	logic [PTR_W-1:0]         wr_next;
	logic [PTR_W-1:0]         rd_next;
	logic [PTR_W-1:0]         rd_addr;
	logic                     wr_en;
	logic [CNT_W-1:0]         count_d;
	result_t                  res;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		wr_next = (wr_slot_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_slot_q + 1'b1;
		rd_next = (rd_slot_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_slot_q + 1'b1;

		enq_ok = 1'b0;
		ack    = 1'b0;
		res    = '0;
		case (func_s1)
			FUNC_ENQUEUE: begin
				if (addr_s1 == '0) begin
					res.status = STATUS_NULL;
				end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
					res.status = STATUS_FULL;
				end else begin
					res.status = STATUS_OK;
					enq_ok     = 1'b1;
				end
			end
			FUNC_IRQ: begin
				ack = ((flags_s1 & (CTRL_X2 | CTRL_Y2)) == (CTRL_X2 | CTRL_Y2));
			end
			default: begin
				res.status = STATUS_OK;
			end
		endcase

		cred_up = (ack && credits_q < CREDIT_MAX) ? credits_q + 6'sd1 : credits_q;
		may_send = enq_ok || ack;

		wdata = {extra_s1, addr_s1};
		head  = byp_q ? byp_data_q : rdata_q;
		// empty ring: the only candidate is the request just taken
		entry = (count_q == '0) ? wdata : head;

		send_ok = may_send && (cred_up > 6'sd0) && ((count_q != '0) || enq_ok);
		cred_d  = send_ok ? (cred_up - (entry[ADDR_W] ? 6'sd2 : 6'sd1)) : cred_up;

		count_d = count_q + CNT_W'(enq_ok) - CNT_W'(send_ok);

		res.ack_issued     = ack;
		res.ack_ctrl_value = ack ? ((flags_s1 & IRQ_MASK) | CTRL_Y2) : '0;
		res.send_valid     = send_ok;
		res.send_address   = send_ok ? (entry[ADDR_W-1:0] - ADDR_OFFSET) : '0;
		res.kick_ctrl_value = send_ok ? ((flags_s1 & IRQ_MASK) | CTRL_X1) : '0;

		wr_en   = advance && enq_ok;
		rd_addr = (advance && send_ok) ? rd_next : rd_slot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1  <= s_tuser;
			addr_s1  <= s_tdata[ADDR_W-1:0];
			extra_s1 <= s_tdata[ADDR_W];
			flags_s1 <= s_tdata[ADDR_W+FLAGS_W:ADDR_W+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			count_q   <= '0;
			credits_q <= CREDIT_RESET;
		end else if (advance) begin
			if (enq_ok) begin
				wr_slot_q <= wr_next;
			end
			if (send_ok) begin
				rd_slot_q <= rd_next;
			end
			count_q   <= count_d;
			credits_q <= cred_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_q[wr_slot_q] <= wdata;
		end
		rdata_q    <= ring_q[rd_addr];
		byp_q      <= wr_en && (wr_slot_q == rd_addr);
		byp_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire

// ===== rtl/ircq_checker.sv =====
`default_nettype none

module ircq_checker
	import ircq_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	result_t res;
	assign res = m_tdata;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.status == STATUS_OK || res.status == STATUS_FULL ||
			res.status == STATUS_NULL))
		else $error("bad status code");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status != STATUS_OK |-> !res.send_valid && !res.ack_issued)
		else $error("rejected request sent or acknowledged");

	a_nosend: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.send_valid |-> res.send_address == '0 &&
			res.kick_ctrl_value == '0)
		else $error("send fields set without a send");

	a_kick: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.send_valid |-> res.kick_ctrl_value[0] &&
			(res.ack_ctrl_value[0] == 1'b0))
		else $error("kick or acknowledge value malformed");

endmodule

bind ipc_request_credit_queue ircq_checker u_ircq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
